// ===== design/u2c_pkg.sv =====
`default_nettype none
package u2c_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned REM_W  = 2;

    // lead byte classes (masked prefix compare)
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // payload masks
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    // continuation bytes still expected after each lead
    localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
    localparam logic [REM_W-1:0] REM_LEAD2 = 2'd1;
    localparam logic [REM_W-1:0] REM_LEAD3 = 2'd2;
    localparam logic [REM_W-1:0] REM_LEAD4 = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0]  partial;
        logic [REM_W-1:0] remaining;
    } dec_state_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
    } dec_result_t;

endpackage
`default_nettype wire

// ===== design/u2c_step.sv =====
`default_nettype none
module u2c_step (
    input  wire logic [u2c_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       end_of_text,
    input  wire u2c_pkg::dec_state_t        cur_state,
    output u2c_pkg::dec_state_t             nxt_state,
    output u2c_pkg::dec_result_t            result
);
    import u2c_pkg::*;

    logic [CP_W-1:0]  shifted;
    logic [REM_W-1:0] rem_dec;
    dec_state_t       decoded;

    // six more bits in; the top bits fall off the 21-bit value
    assign shifted = {cur_state.partial[CP_W-7:0], in_byte[5:0] & CONT_BITS[5:0]};
    assign rem_dec = cur_state.remaining - REM_W'(1);

    always_comb
    begin
        decoded           = cur_state;
        result.emit       = 1'b0;
        result.code_point = shifted;
        if ((in_byte & CONT_MASK) == CONT_CODE)
        begin
            if (cur_state.remaining != REM_NONE)
            begin
                decoded.remaining = rem_dec;
                decoded.partial   = shifted;
                if (rem_dec == REM_NONE)
                begin
                    result.emit     = 1'b1;
                    decoded.partial = '0;
                end
            end
        end
        else
        begin
            // non-continuation drops whatever was pending
            decoded.partial   = '0;
            decoded.remaining = REM_NONE;
            if (in_byte[BYTE_W-1] == 1'b0)
            begin
                result.emit       = 1'b1;
                result.code_point = CP_W'(in_byte);
            end
            else if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                decoded.partial   = CP_W'(in_byte & LEAD2_BITS);
                decoded.remaining = REM_LEAD2;
            end
            else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                decoded.partial   = CP_W'(in_byte & LEAD3_BITS);
                decoded.remaining = REM_LEAD3;
            end
            else if ((in_byte & LEAD4_MASK) == LEAD4_CODE)
            begin
                decoded.partial   = CP_W'(in_byte & LEAD4_BITS);
                decoded.remaining = REM_LEAD4;
            end
        end
        nxt_state = decoded;
        if (end_of_text)
        begin
            nxt_state.partial   = '0;
            nxt_state.remaining = REM_NONE;
        end
    end

endmodule
`default_nettype wire

// ===== design/u2c_obuf.sv =====
`default_nettype none
module u2c_obuf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire u2c_pkg::dec_result_t       result,
    output logic                            free,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [u2c_pkg::CP_W-1:0]        code_point
);
    import u2c_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [CP_W-1:0] cp_reg;

    // room when empty or the held item leaves this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
            valid_next = load && result.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (free && load && result.emit)
            cp_reg <= result.code_point;
    end

    assign out_valid  = valid_reg;
    assign code_point = cp_reg;

endmodule
`default_nettype wire

// ===== design/utf8_to_codepoint_decoder_core.sv =====
`default_nettype none
// path: a byte goes through the input register and then the result register;
//   a full result register holds it in the input register
// throughput: one byte per cycle while out_stall is low; bytes that close no
//   sequence still pass through the decode slot
// reset: rst_n asynchronous, active low; clears valid flags and decode state
//   (no sequence pending); payload registers are not reset
module utf8_to_codepoint_decoder_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [u2c_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       end_of_text,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [u2c_pkg::CP_W-1:0]        code_point
);
    import u2c_pkg::*;

    // input register: one byte waiting for the decode slot
    logic              in_v_reg;
    logic              in_v_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              eot_reg;

    // decode state: partial value and continuation bytes still owed
    dec_state_t        state_reg;
    dec_state_t        state_next;
    dec_result_t       step_res;

    logic              out_free;
    logic              advance;
    logic              in_take;

    // the held byte is decoded when the result register has room
    assign advance  = in_v_reg && out_free;
    // stall only while a byte is held and cannot move on
    assign in_stall = in_v_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_take)
            in_v_next = 1'b1;
        else if (advance)
            in_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            in_v_reg <= in_v_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_byte;
            eot_reg  <= end_of_text;
        end
    end

    // shift-or and remaining count update for one byte
    u2c_step u_step (
        .in_byte     (byte_reg),
        .end_of_text (eot_reg),
        .cur_state   (state_reg),
        .nxt_state   (state_next),
        .result      (step_res)
    );

    // result register, loads while downstream may stall
    u2c_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (step_res),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point)
    );

`ifndef ASSERT_OFF
    // with nothing pending the partial value is always cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.remaining == REM_NONE |-> state_reg.partial == '0)
        else $error("partial value left over with no sequence pending");

    // end of text always leaves the decoder with nothing pending
    a_eot_flush: assert property (@(posedge clk) disable iff (!rst_n)
        advance && eot_reg |=> state_reg.remaining == REM_NONE)
        else $error("sequence still pending after end of text");

    // input side only stalls while a byte is held behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_v_reg && out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // a decoded byte with a result always shows up at the output next cycle
    a_emit_seen: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.emit |=> out_valid)
        else $error("decoded result lost");
`endif

endmodule
`default_nettype wire
